@@ rtl/dte_pkg.sv @@
// Shared types and constants for the DNS text escape decoder.
// Used by every module of the block; depends on nothing.
`default_nettype none

package dte_pkg;

    // Result kinds as seen on the output port
    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_EMPTY = 2'd2,
        KIND_OVER  = 2'd3
    } t_kind;

    // Front-end parser modes
    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_DOT    = 3'd1,
        MODE_ESC    = 3'd2,
        MODE_ESC1   = 3'd3,
        MODE_ESC2   = 3'd4,
        MODE_QUOTE  = 3'd5,
        MODE_DEAD   = 3'd6
    } t_mode;

    // Characters with special meaning
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Largest value a decimal escape may take
    localparam logic [9:0] ESC_MAX = 10'd255;

    // Byte counter
    localparam int COUNT_W = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    // Results per input item and their indexing
    localparam int MAX_RES   = 4;
    localparam int RES_IDX_W = $clog2(MAX_RES);
    localparam int RES_NUM_W = $clog2(MAX_RES + 1);

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    // One result before the byte count is attached
    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
    } t_result;

    // All results caused by one input item, in order from slot 0
    typedef struct packed {
        logic [RES_NUM_W-1:0]          num;
        t_result [MAX_RES-1:0]         res;
    } t_cmd;

endpackage

`default_nettype wire

@@ rtl/dte_front.sv @@
// Front end: accepts characters, tracks escape/quote/dot state and turns each
// item into a command of up to four results. Depends on dte_pkg.
`default_nettype none

module dte_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [7:0]    i_ch,
    input  wire logic          i_end_req,
    input  wire logic          i_q_full,
    output logic               o_ready,
    output logic               o_push,
    output dte_pkg::t_cmd      o_cmd
);

    dte_pkg::t_mode r_mode, n_mode;
    logic [3:0]     r_held0, n_held0;
    logic [3:0]     r_held1, n_held1;

    logic                       w_accept;
    logic                       w_is_digit;
    logic [3:0]                 w_digit;
    logic [9:0]                 w_val;
    logic                       f_over;
    logic [1:0]                 f_flush;
    logic                       f_plain;
    logic                       f_base_dot;
    logic                       f_tail;
    dte_pkg::t_result           f_tail_res;
    logic [dte_pkg::RES_NUM_W-1:0] v_idx;
    dte_pkg::t_cmd              w_cmd;

    // Hold off while the queue has no room
    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && o_ready;

    // Classify the character
    assign w_is_digit = i_ch inside {[dte_pkg::CH_ZERO:dte_pkg::CH_NINE]};
    assign w_digit    = 4'(i_ch - dte_pkg::CH_ZERO);
    assign w_val      = 10'({6'd0, r_held0} * 10'd100) + 10'({6'd0, r_held1} * 10'd10)
                      + {6'd0, w_digit};

    // Decide the actions for this item and the next mode
    always_comb begin
        n_mode     = r_mode;
        n_held0    = r_held0;
        n_held1    = r_held1;
        f_over     = 1'b0;
        f_flush    = 2'd0;
        f_plain    = 1'b0;
        f_base_dot = 1'b0;
        f_tail     = 1'b0;
        f_tail_res = '{data: i_ch, kind: dte_pkg::KIND_DATA};
        if (i_end_req) begin
            if (r_mode == dte_pkg::MODE_ESC1) begin
                f_flush = 2'd1;
            end else if (r_mode == dte_pkg::MODE_ESC2) begin
                f_flush = 2'd2;
            end
            f_tail     = 1'b1;
            f_tail_res = '{data: 8'd0, kind: dte_pkg::KIND_DONE};
            n_mode     = dte_pkg::MODE_NORMAL;
            n_held0    = 4'd0;
            n_held1    = 4'd0;
        end else begin
            case (r_mode)
                dte_pkg::MODE_DEAD: begin
                end
                dte_pkg::MODE_ESC: begin
                    if (w_is_digit) begin
                        n_held0 = w_digit;
                        n_mode  = dte_pkg::MODE_ESC1;
                    end else begin
                        f_tail = 1'b1;
                        n_mode = dte_pkg::MODE_NORMAL;
                    end
                end
                dte_pkg::MODE_ESC1: begin
                    if (w_is_digit) begin
                        n_held1 = w_digit;
                        n_mode  = dte_pkg::MODE_ESC2;
                    end else begin
                        f_flush = 2'd1;
                        f_plain = 1'b1;
                    end
                end
                dte_pkg::MODE_ESC2: begin
                    if (w_is_digit) begin
                        n_mode = dte_pkg::MODE_NORMAL;
                        f_tail = 1'b1;
                        if (w_val <= dte_pkg::ESC_MAX) begin
                            f_tail_res.data = w_val[7:0];
                        end else begin
                            f_over  = 1'b1;
                            f_flush = 2'd2;
                        end
                    end else begin
                        f_flush = 2'd2;
                        f_plain = 1'b1;
                    end
                end
                dte_pkg::MODE_QUOTE: begin
                    f_tail = 1'b1;
                    n_mode = dte_pkg::MODE_NORMAL;
                end
                dte_pkg::MODE_DOT: begin
                    f_plain    = 1'b1;
                    f_base_dot = 1'b1;
                end
                default: begin
                    f_plain = 1'b1;
                end
            endcase

            // Handle an unescaped character
            if (f_plain) begin
                case (i_ch)
                    dte_pkg::CH_DOT: begin
                        f_tail = 1'b1;
                        if (f_base_dot) begin
                            f_tail_res = '{data: 8'd0, kind: dte_pkg::KIND_EMPTY};
                            n_mode     = dte_pkg::MODE_DEAD;
                        end else begin
                            n_mode = dte_pkg::MODE_DOT;
                        end
                    end
                    dte_pkg::CH_BSL: begin
                        n_mode = dte_pkg::MODE_ESC;
                    end
                    dte_pkg::CH_QUOTE: begin
                        n_mode = dte_pkg::MODE_QUOTE;
                    end
                    default: begin
                        f_tail = 1'b1;
                        n_mode = dte_pkg::MODE_NORMAL;
                    end
                endcase
            end
        end
    end

    // Assemble the results in order: overflow, held digits, final result
    always_comb begin
        w_cmd = '0;
        v_idx = '0;
        if (f_over) begin
            w_cmd.res[v_idx[dte_pkg::RES_IDX_W-1:0]] =
                '{data: 8'd0, kind: dte_pkg::KIND_OVER};
            v_idx = v_idx + 1'b1;
        end
        if (f_flush != 2'd0) begin
            w_cmd.res[v_idx[dte_pkg::RES_IDX_W-1:0]] =
                '{data: dte_pkg::CH_ZERO + {4'd0, r_held0}, kind: dte_pkg::KIND_DATA};
            v_idx = v_idx + 1'b1;
        end
        if (f_flush == 2'd2) begin
            w_cmd.res[v_idx[dte_pkg::RES_IDX_W-1:0]] =
                '{data: dte_pkg::CH_ZERO + {4'd0, r_held1}, kind: dte_pkg::KIND_DATA};
            v_idx = v_idx + 1'b1;
        end
        if (f_tail) begin
            w_cmd.res[v_idx[dte_pkg::RES_IDX_W-1:0]] = f_tail_res;
            v_idx = v_idx + 1'b1;
        end
        w_cmd.num = v_idx;
    end

    assign o_push = w_accept && (w_cmd.num != '0);
    assign o_cmd  = w_cmd;

    // Advance parser state on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= dte_pkg::MODE_NORMAL;
            r_held0 <= 4'd0;
            r_held1 <= 4'd0;
        end else if (w_accept) begin
            r_mode  <= n_mode;
            r_held0 <= n_held0;
            r_held1 <= n_held1;
        end
    end

endmodule

`default_nettype wire

@@ rtl/dte_queue.sv @@
// Small register queue of result commands between front and back.
// Depends on dte_pkg.
`default_nettype none

module dte_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  dte_pkg::t_cmd      i_cmd,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_head_valid,
    output dte_pkg::t_cmd      o_head
);

    dte_pkg::t_cmd                 r_mem [dte_pkg::QUEUE_DEPTH];
    logic [dte_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [dte_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [dte_pkg::QFILL_W-1:0]   r_fill;

    assign o_full       = (r_fill == dte_pkg::QFILL_W'(dte_pkg::QUEUE_DEPTH));
    assign o_head_valid = (r_fill != '0);
    assign o_head       = r_mem[r_rd_ptr];

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == dte_pkg::QPTR_W'(dte_pkg::QUEUE_DEPTH - 1))
                          ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == dte_pkg::QPTR_W'(dte_pkg::QUEUE_DEPTH - 1))
                          ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/dte_back.sv @@
// Back end: walks the results of the head command one per cycle while not stalled,
// attaches the running byte count and drives the output register. Depends on dte_pkg.
`default_nettype none

module dte_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_head_valid,
    input  dte_pkg::t_cmd      i_head,
    output logic               o_pop,
    input  wire logic          i_ready,
    output logic               o_valid,
    output logic [7:0]         o_out_byte,
    output logic [1:0]         o_kind,
    output logic [15:0]        o_count,
    output logic               o_last
);

    logic [dte_pkg::RES_IDX_W-1:0] r_idx;
    logic [dte_pkg::COUNT_W-1:0]   r_cnt, n_cnt;
    logic [dte_pkg::COUNT_W-1:0]   w_out_cnt;
    logic                          r_valid;
    logic [7:0]                    r_data;
    dte_pkg::t_kind                r_kind;
    logic [dte_pkg::COUNT_W-1:0]   r_count;
    logic                          r_last;

    logic                          w_load;
    logic                          w_last;
    dte_pkg::t_result              w_res;

    assign w_load = i_head_valid && (!r_valid || i_ready);
    assign w_res  = i_head.res[r_idx];
    assign w_last = (({1'b0, r_idx} + 1'b1) == i_head.num);
    assign o_pop  = w_load && w_last;

    // Count data bytes, saturating; clear after the done result
    always_comb begin
        n_cnt     = r_cnt;
        w_out_cnt = r_cnt;
        case (w_res.kind)
            dte_pkg::KIND_DATA: begin
                n_cnt     = (r_cnt == dte_pkg::COUNT_MAX) ? r_cnt : r_cnt + 1'b1;
                w_out_cnt = n_cnt;
            end
            dte_pkg::KIND_DONE: begin
                n_cnt = '0;
            end
            default: begin
            end
        endcase
    end

    // Advance the slot index and byte count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_idx <= w_last ? '0 : r_idx + 1'b1;
                r_cnt <= n_cnt;
            end
            if (w_load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data  <= w_res.data;
            r_kind  <= w_res.kind;
            r_count <= w_out_cnt;
            r_last  <= w_last;
        end
    end

    assign o_valid    = r_valid;
    assign o_out_byte = r_data;
    assign o_kind     = r_kind;
    assign o_count    = r_count;
    assign o_last     = r_last;

endmodule

`default_nettype wire

@@ rtl/dns_text_escape_decoder.sv @@
// Top level of the DNS text escape decoder: front parser, command queue and
// result back end. Depends on dte_pkg, dte_front, dte_queue and dte_back.
//
//   channel   handshake           payload
//   input     i_valid / o_ready   i_ch, i_end_req
//   output    o_valid / i_ready   o_out_byte, o_kind, o_count, o_last
//
// One character is taken per cycle while the two-entry command queue has room.
// The back end sends one result per cycle while the output is not stalled, so an
// item with several results (at most 4) holds the output until all are sent.
// An item's first result is registered in a queue entry and then in the output register.
// Synchronous reset clears parser mode, queue and counters.
// Either side may stall; the queue and output register absorb the difference.
`default_nettype none

module dns_text_escape_decoder (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [7:0]    i_ch,
    input  wire logic          i_end_req,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [7:0]         o_out_byte,
    output logic [1:0]         o_kind,
    output logic [15:0]        o_count,
    output logic               o_last
);

    logic           w_q_full;
    logic           w_push;
    dte_pkg::t_cmd  w_push_cmd;
    logic           w_pop;
    logic           w_head_valid;
    dte_pkg::t_cmd  w_head;

    // Parse incoming characters
    dte_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_ch      (i_ch),
        .i_end_req (i_end_req),
        .i_q_full  (w_q_full),
        .o_ready   (o_ready),
        .o_push    (w_push),
        .o_cmd     (w_push_cmd)
    );

    // Buffer result commands
    dte_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_cmd        (w_push_cmd),
        .i_pop        (w_pop),
        .o_full       (w_q_full),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    // Emit results
    dte_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_out_byte   (o_out_byte),
        .o_kind       (o_kind),
        .o_count      (o_count),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

@@ rtl/dte_checker.sv @@
// Port-level checks for the DNS text escape decoder, bound to the top level.
// Depends on dte_pkg and dns_text_escape_decoder.
`default_nettype none

module dte_checker (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          o_valid,
    input  wire logic          i_ready,
    input  wire logic [7:0]    o_out_byte,
    input  wire logic [1:0]    o_kind,
    input  wire logic [15:0]   o_count,
    input  wire logic          o_last
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_byte) && $stable(o_kind)
            && $stable(o_count) && $stable(o_last))
        else $error("output result changed while stalled");

    // Non-data results carry a zero byte
    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind != dte_pkg::KIND_DATA) |-> o_out_byte == 8'd0)
        else $error("non-data result with nonzero byte");

    // String done ends its item
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == dte_pkg::KIND_DONE) |-> o_last)
        else $error("string done without last");

    // Overflow is always followed by the literal digits
    a_over_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == dte_pkg::KIND_OVER) |-> !o_last)
        else $error("overflow marked last");

    // A data byte has been counted
    a_data_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == dte_pkg::KIND_DATA) |-> o_count != 16'd0)
        else $error("data result with zero count");

endmodule

bind dns_text_escape_decoder dte_checker u_dte_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_out_byte (o_out_byte),
    .o_kind     (o_kind),
    .o_count    (o_count),
    .o_last     (o_last)
);

`default_nettype wire

@@ tb/dns_text_escape_decoder_tb.sv @@
// Self-checking bench for the DNS text escape decoder: a directed table of
// strings followed by random strings. Depends on dte_pkg and dns_text_escape_decoder.
`default_nettype none

module dns_text_escape_decoder_tb;

    localparam int QUIET_LIMIT   = 2000;
    localparam int ITEM_TARGET   = 160;
    localparam int DRAIN_CYCLES  = 8;
    localparam int IDLE_PCT      = 24;
    localparam int CALM_START    = 150;
    localparam int CALM_END      = 350;

    // One decoded result as it should appear on the output port
    typedef struct {
        logic [7:0]      data;
        dte_pkg::t_kind  kind;
        logic [15:0]     count;
        logic            last;
    } t_dec_res;

    // Directed row; typed rows carry their single result inline
    typedef struct {
        logic [7:0]      ch;
        logic            e;
        bit              typed;
        logic [7:0]      exp_data;
        dte_pkg::t_kind  exp_kind;
        logic [15:0]     exp_count;
    } t_dir_row;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        i_valid   = 1'b0;
    logic [7:0]  i_ch      = 8'h00;
    logic        i_end_req = 1'b0;
    logic        i_ready   = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [7:0]  o_out_byte;
    logic [1:0]  o_kind;
    logic [15:0] o_count;
    logic        o_last;

    // Decoder state mirrored by the predictor
    dte_pkg::t_mode dec_mode   = dte_pkg::MODE_NORMAL;
    logic [3:0]     held [2]   = '{4'h0, 4'h0};
    logic [15:0]    byte_count = 16'd0;

    t_dec_res    step_res [$];
    t_dec_res    decoded_q [$];
    t_dir_row    dir_tab [0:27];

    int          fail_cnt   = 0;
    int          res_cnt    = 0;
    int          str_cnt    = 0;
    int          item_cnt   = 0;
    int          cyc_cnt    = 0;
    int          quiet_cnt  = 0;

    dns_text_escape_decoder u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_ch       (i_ch),
        .i_end_req  (i_end_req),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_byte (o_out_byte),
        .o_kind     (o_kind),
        .o_count    (o_count),
        .o_last     (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Random idle, switched off in one long calm window early in the run
    function automatic bit idle_now();
        return !(cyc_cnt >= CALM_START && cyc_cnt < CALM_END)
            && ($urandom_range(99) < IDLE_PCT);
    endfunction

    // ---------------- predictor ----------------

    function automatic void add_res(input logic [7:0] b, input dte_pkg::t_kind k);
        logic [7:0] d;
        d = (k == dte_pkg::KIND_DATA) ? b : 8'h00;
        if (step_res.size() < dte_pkg::MAX_RES) begin
            if (k == dte_pkg::KIND_DATA && byte_count != dte_pkg::COUNT_MAX)
                byte_count = byte_count + 16'd1;
            step_res.push_back('{d, k, byte_count, 1'b0});
        end
    endfunction

    function automatic bit is_digit(input logic [7:0] ch);
        return ch >= dte_pkg::CH_ZERO && ch <= dte_pkg::CH_NINE;
    endfunction

    // Emit held escape digits as literal characters
    function automatic void flush_held(input int n);
        for (int i = 0; i < n; i++)
            add_res(dte_pkg::CH_ZERO + {4'h0, held[i]}, dte_pkg::KIND_DATA);
        dec_mode = dte_pkg::MODE_NORMAL;
    endfunction

    // Character seen in normal or after-dot mode
    function automatic void plain_char(input logic [7:0] ch);
        if (ch == dte_pkg::CH_DOT) begin
            if (dec_mode == dte_pkg::MODE_DOT) begin
                add_res(8'h00, dte_pkg::KIND_EMPTY);
                dec_mode = dte_pkg::MODE_DEAD;
            end else begin
                add_res(ch, dte_pkg::KIND_DATA);
                dec_mode = dte_pkg::MODE_DOT;
            end
        end else if (ch == dte_pkg::CH_BSL) begin
            dec_mode = dte_pkg::MODE_ESC;
        end else if (ch == dte_pkg::CH_QUOTE) begin
            dec_mode = dte_pkg::MODE_QUOTE;
        end else begin
            add_res(ch, dte_pkg::KIND_DATA);
            dec_mode = dte_pkg::MODE_NORMAL;
        end
    endfunction

    // Work out the results of one input item into step_res
    function automatic void decode_char(input logic [7:0] ch, input logic e);
        int unsigned val;
        step_res.delete();
        if (e) begin
            if (dec_mode == dte_pkg::MODE_ESC1)
                flush_held(1);
            else if (dec_mode == dte_pkg::MODE_ESC2)
                flush_held(2);
            add_res(8'h00, dte_pkg::KIND_DONE);
            dec_mode   = dte_pkg::MODE_NORMAL;
            held[0]    = 4'h0;
            held[1]    = 4'h0;
            byte_count = 16'd0;
        end else begin
            case (dec_mode)
                dte_pkg::MODE_DEAD: begin
                end
                dte_pkg::MODE_ESC: begin
                    if (is_digit(ch)) begin
                        held[0]  = ch[3:0];
                        dec_mode = dte_pkg::MODE_ESC1;
                    end else begin
                        add_res(ch, dte_pkg::KIND_DATA);
                        dec_mode = dte_pkg::MODE_NORMAL;
                    end
                end
                dte_pkg::MODE_ESC1: begin
                    if (is_digit(ch)) begin
                        held[1]  = ch[3:0];
                        dec_mode = dte_pkg::MODE_ESC2;
                    end else begin
                        flush_held(1);
                        plain_char(ch);
                    end
                end
                dte_pkg::MODE_ESC2: begin
                    if (is_digit(ch)) begin
                        val = held[0] * 100 + held[1] * 10 + ch[3:0];
                        if (val <= dte_pkg::ESC_MAX) begin
                            add_res(val[7:0], dte_pkg::KIND_DATA);
                            dec_mode = dte_pkg::MODE_NORMAL;
                        end else begin
                            add_res(8'h00, dte_pkg::KIND_OVER);
                            flush_held(2);
                            add_res(ch, dte_pkg::KIND_DATA);
                        end
                    end else begin
                        flush_held(2);
                        plain_char(ch);
                    end
                end
                dte_pkg::MODE_QUOTE: begin
                    add_res(ch, dte_pkg::KIND_DATA);
                    dec_mode = dte_pkg::MODE_NORMAL;
                end
                dte_pkg::MODE_DOT: begin
                    plain_char(ch);
                end
                default: begin
                    dec_mode = dte_pkg::MODE_NORMAL;
                    plain_char(ch);
                end
            endcase
        end
        if (step_res.size() > 0)
            step_res[step_res.size() - 1].last = 1'b1;
    endfunction

    // ---------------- stimulus ----------------

    // Present one item and hold it until the transfer
    task automatic transfer_char(input logic [7:0] ch, input logic e);
        while (idle_now()) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_ch      <= ch;
        i_end_req <= e;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        item_cnt++;
    endtask

    // Transfer one item and queue the predicted results
    task automatic put_char(input logic [7:0] ch, input logic e);
        transfer_char(ch, e);
        decode_char(ch, e);
        foreach (step_res[i])
            decoded_q.push_back(step_res[i]);
    endtask

    function automatic logic [7:0] rand_digit(input int hi);
        return dte_pkg::CH_ZERO + 8'($urandom_range(hi));
    endfunction

    // One random string built mostly from well-formed tokens
    task automatic send_string();
        int n_tok;
        int cls;
        n_tok = $urandom_range(0, 10);
        for (int t = 0; t < n_tok; t++) begin
            cls = $urandom_range(99);
            if (cls < 25) begin
                put_char(8'($urandom_range(255)), 1'b0);
            end else if (cls < 40) begin
                put_char(dte_pkg::CH_DOT, 1'b0);
            end else if (cls < 58) begin
                // full decimal escape, sometimes above 255
                put_char(dte_pkg::CH_BSL, 1'b0);
                put_char(rand_digit(($urandom_range(3) == 0) ? 9 : 2), 1'b0);
                put_char(rand_digit(9), 1'b0);
                put_char(rand_digit(9), 1'b0);
            end else if (cls < 66) begin
                // short decimal escape, cut off by whatever comes next
                put_char(dte_pkg::CH_BSL, 1'b0);
                put_char(rand_digit(9), 1'b0);
                if ($urandom_range(1))
                    put_char(rand_digit(9), 1'b0);
            end else if (cls < 76) begin
                put_char(dte_pkg::CH_BSL, 1'b0);
                put_char(8'($urandom_range(255)), 1'b0);
            end else if (cls < 86) begin
                put_char(dte_pkg::CH_QUOTE, 1'b0);
                put_char(8'($urandom_range(255)), 1'b0);
            end else begin
                put_char(8'($urandom_range(8'h7A, 8'h61)), 1'b0);
            end
        end
        put_char(8'($urandom_range(255)), 1'b1);
    endtask

    initial begin
        dir_tab = '{
            '{8'h00,            1'b1, 1'b1, 8'h00,          dte_pkg::KIND_DONE,  16'd0},
            '{8'hFF,            1'b0, 1'b1, 8'hFF,          dte_pkg::KIND_DATA,  16'd1},
            '{dte_pkg::CH_DOT,  1'b0, 1'b1, dte_pkg::CH_DOT, dte_pkg::KIND_DATA, 16'd2},
            '{dte_pkg::CH_DOT,  1'b0, 1'b1, 8'h00,          dte_pkg::KIND_EMPTY, 16'd2},
            '{8'h78,            1'b0, 1'b0, 8'h00,          dte_pkg::KIND_DATA,  16'd0},
            '{8'h00,            1'b1, 1'b1, 8'h00,          dte_pkg::KIND_DONE,  16'd2},
            '{dte_pkg::CH_BSL,  1'b0, 1'b0, 8'h00,          dte_pkg::KIND_DATA,  16'd0},
            '{8'h32,            1'b0, 1'b0, 8'h00,          dte_pkg::KIND_DATA,  16'd0},
            '{8'h35,            1'b0, 1'b0, 8'h00,          dte_pkg::KIND_DATA,  16'd0},
            '{8'h35,            1'b0, 1'b1, 8'hFF,          dte_pkg::KIND_DATA,  16'd1},
            '{dte_pkg::CH_BSL,  1'b0, 1'b0, 8'h00,          dte_pkg::KIND_DATA,  16'd0},
            '{8'h32,            1'b0, 1'b0, 8'h00,          dte_pkg::KIND_DATA,  16'd0},
            '{8'h35,            1'b0, 1'b0, 8'h00,          dte_pkg::KIND_DATA,  16'd0},
            '{8'h36,            1'b0, 1'b0, 8'h00,          dte_pkg::KIND_DATA,  16'd0},
            '{dte_pkg::CH_BSL,  1'b0, 1'b0, 8'h00,          dte_pkg::KIND_DATA,  16'd0},
            '{dte_pkg::CH_DOT,  1'b0, 1'b0, 8'h00,          dte_pkg::KIND_DATA,  16'd0},
            '{dte_pkg::CH_DOT,  1'b0, 1'b0, 8'h00,          dte_pkg::KIND_DATA,  16'd0},
            '{dte_pkg::CH_BSL,  1'b0, 1'b0, 8'h00,          dte_pkg::KIND_DATA,  16'd0},
            '{8'h34,            1'b0, 1'b0, 8'h00,          dte_pkg::KIND_DATA,  16'd0},
            '{8'h32,            1'b0, 1'b0, 8'h00,          dte_pkg::KIND_DATA,  16'd0},
            '{dte_pkg::CH_QUOTE, 1'b0, 1'b0, 8'h00,         dte_pkg::KIND_DATA,  16'd0},
            '{dte_pkg::CH_DOT,  1'b0, 1'b0, 8'h00,          dte_pkg::KIND_DATA,  16'd0},
            '{dte_pkg::CH_BSL,  1'b0, 1'b0, 8'h00,          dte_pkg::KIND_DATA,  16'd0},
            '{8'h37,            1'b0, 1'b0, 8'h00,          dte_pkg::KIND_DATA,  16'd0},
            '{dte_pkg::CH_QUOTE, 1'b0, 1'b0, 8'h00,         dte_pkg::KIND_DATA,  16'd0},
            '{8'h00,            1'b1, 1'b0, 8'h00,          dte_pkg::KIND_DATA,  16'd0},
            '{dte_pkg::CH_BSL,  1'b0, 1'b0, 8'h00,          dte_pkg::KIND_DATA,  16'd0},
            '{8'hA5,            1'b1, 1'b1, 8'h00,          dte_pkg::KIND_DONE,  16'd0}
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed strings: extremes, empty label, escapes, quotes, trailing cases
        foreach (dir_tab[r]) begin
            if (dir_tab[r].typed) begin
                transfer_char(dir_tab[r].ch, dir_tab[r].e);
                decode_char(dir_tab[r].ch, dir_tab[r].e);
                decoded_q.push_back('{dir_tab[r].exp_data, dir_tab[r].exp_kind,
                                      dir_tab[r].exp_count, 1'b1});
            end else begin
                put_char(dir_tab[r].ch, dir_tab[r].e);
            end
        end

        // Random strings mixed with bursts of raw noise
        while (item_cnt < ITEM_TARGET) begin
            if ($urandom_range(99) < 80) begin
                send_string();
            end else begin
                repeat ($urandom_range(4, 1))
                    put_char(8'($urandom_range(255)), ($urandom_range(7) == 0));
            end
        end
        put_char(8'h00, 1'b1);
        i_valid <= 1'b0;

        // Drain outstanding results, then allow for stray ones
        while (decoded_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d input items; checked %0d results over %0d strings.",
                 item_cnt, res_cnt, str_cnt);
        if (fail_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // ---------------- receiver, checker, watchdog ----------------

    always @(posedge i_clk)
        i_ready <= !idle_now();

    // Compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_dec_res want;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            res_cnt++;
            if (decoded_q.size() == 0) begin
                $error("unexpected result: out_byte %0h kind %0d count %0d last %0b",
                       o_out_byte, o_kind, o_count, o_last);
                fail_cnt++;
            end else begin
                want = decoded_q.pop_front();
                if (want.kind == dte_pkg::KIND_DONE)
                    str_cnt++;
                if (o_out_byte !== want.data) begin
                    $error("out_byte: expected %0h, got %0h", want.data, o_out_byte);
                    fail_cnt++;
                end
                if (o_kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, o_kind);
                    fail_cnt++;
                end
                if (o_count !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count, o_count);
                    fail_cnt++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, o_last);
                    fail_cnt++;
                end
            end
        end
    end

    // Stop the run if neither channel moves for too long
    always @(posedge i_clk) begin
        cyc_cnt++;
        if ((i_valid && o_ready === 1'b1) || (o_valid === 1'b1 && i_ready))
            quiet_cnt = 0;
        else
            quiet_cnt++;
        if (quiet_cnt >= QUIET_LIMIT) begin
            $display("Timeout: no transfer in %0d cycles", QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/dte_pkg.sv
rtl/dte_front.sv
rtl/dte_queue.sv
rtl/dte_back.sv
rtl/dns_text_escape_decoder.sv
rtl/dte_checker.sv
tb/dns_text_escape_decoder_tb.sv
